### rtl/core/u8cd_pkg.sv
// ----------------------------------------------------------------------------
// u8cd_pkg: shared types and constants of the UTF-8 codepoint decoder
// Holds the codepoint width, the byte masks, the replacement codepoint and
// the job record that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package u8cd_pkg;

    localparam int CP_W        = 21;
    localparam int BYTE_W      = 8;
    localparam int SEQ_W       = 3;
    localparam int REP_W       = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(63);

    // Lead byte patterns and their payload masks.
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;

    localparam logic [SEQ_W-1:0] SEQ_IDLE = 3'd0;
    localparam logic [SEQ_W-1:0] SEQ_TWO  = 3'd2;
    localparam logic [SEQ_W-1:0] SEQ_THREE = 3'd3;
    localparam logic [SEQ_W-1:0] SEQ_FOUR = 3'd4;

    // One job: a number of replacement results followed by an optional
    // final codepoint. A queued job always yields at least one result.
    typedef struct packed {
        logic [REP_W-1:0] rep_count;
        logic             has_final;
        logic [CP_W-1:0]  final_cp;
    } job_t;

endpackage

### rtl/core/u8cd_front.sv
// ----------------------------------------------------------------------------
// u8cd_front: byte classifier and sequence tracker
// Takes one text byte per beat, tracks the pending multi-byte sequence and
// turns each byte into a job for the back end, or into nothing.
// ----------------------------------------------------------------------------
module u8cd_front
    import u8cd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [BYTE_W-1:0] text_byte,
    output logic              job_push,
    output job_t              job
);

    logic [SEQ_W-1:0] seq_reg,   seq_next;
    logic [SEQ_W-1:0] taken_reg, taken_next;
    logic [CP_W-1:0]  part_reg,  part_next;

    logic             pending;
    logic             is_cont;
    logic [CP_W-1:0]  appended;
    logic [SEQ_W-1:0] taken_inc;
    logic [REP_W-1:0] flush_count;

    assign pending   = (seq_reg != SEQ_IDLE);
    assign is_cont   = ((text_byte & CONT_MASK) == CONT_CODE);
    assign appended  = {part_reg[CP_W-7:0], text_byte[5:0]};
    assign taken_inc = taken_reg + SEQ_W'(1);

    always_comb
    begin
        priority if (taken_reg > SEQ_W'(3))
            flush_count = REP_W'(3);
        else if (taken_reg < SEQ_W'(1))
            flush_count = REP_W'(1);
        else
            flush_count = taken_reg[REP_W-1:0];
    end

    always_comb
    begin
        seq_next       = seq_reg;
        taken_next     = taken_reg;
        part_next      = part_reg;
        job.rep_count  = '0;
        job.has_final  = 1'b0;
        job.final_cp   = REPLACEMENT_CP;

        if (pending && is_cont)
        begin
            if (taken_inc >= seq_reg)
            begin
                job.has_final = 1'b1;
                job.final_cp  = appended;
                seq_next      = SEQ_IDLE;
                taken_next    = '0;
                part_next     = '0;
            end
            else
            begin
                taken_next = taken_inc;
                part_next  = appended;
            end
        end
        else
        begin
            // A broken sequence gives one replacement per byte swallowed,
            // then the new byte is decoded from idle.
            if (pending)
                job.rep_count = flush_count;
            seq_next   = SEQ_IDLE;
            taken_next = '0;
            part_next  = '0;

            priority if (text_byte == '0)
            begin
                job.has_final = 1'b0;
            end
            else if (!text_byte[BYTE_W-1])
            begin
                job.has_final = 1'b1;
                job.final_cp  = CP_W'(text_byte);
            end
            else if ((text_byte & LEAD2_MASK) == LEAD2_CODE)
            begin
                seq_next   = SEQ_TWO;
                taken_next = SEQ_W'(1);
                part_next  = CP_W'(text_byte[4:0]);
            end
            else if ((text_byte & LEAD3_MASK) == LEAD3_CODE)
            begin
                seq_next   = SEQ_THREE;
                taken_next = SEQ_W'(1);
                part_next  = CP_W'(text_byte[3:0]);
            end
            else if ((text_byte & LEAD4_MASK) == LEAD4_CODE)
            begin
                seq_next   = SEQ_FOUR;
                taken_next = SEQ_W'(1);
                part_next  = CP_W'(text_byte[2:0]);
            end
            else
            begin
                job.has_final = 1'b1;
                job.final_cp  = REPLACEMENT_CP;
            end
        end
    end

    assign job_push = take && ((job.rep_count != '0) || job.has_final);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= SEQ_IDLE;
            taken_reg <= '0;
            part_reg  <= '0;
        end
        else if (take)
        begin
            seq_reg   <= seq_next;
            taken_reg <= taken_next;
            part_reg  <= part_next;
        end
    end

`ifndef SYNTHESIS
    a_pending_count: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != SEQ_IDLE) |-> (taken_reg >= SEQ_W'(1) && taken_reg < seq_reg))
        else $error("pending sequence with inconsistent byte count");
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_IDLE) |-> (taken_reg == '0))
        else $error("idle tracker holds a byte count");
`endif

endmodule

### rtl/core/u8cd_job_queue.sv
// ----------------------------------------------------------------------------
// u8cd_job_queue: short job queue between front end and back end
// A small flop-based FIFO that lets the classifier run ahead while the
// expander works through multi-result jobs.
// ----------------------------------------------------------------------------
module u8cd_job_queue
    import u8cd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_en && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("job queue count beyond depth");
`endif

endmodule

### rtl/core/u8cd_back.sv
// ----------------------------------------------------------------------------
// u8cd_back: job expander and result register
// Walks the head job one result per cycle while the result register is free
// or popped, and drives the result register that the consumer pops.
// ----------------------------------------------------------------------------
module u8cd_back
    import u8cd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  job_t            head_job,
    output logic            head_done,
    output logic            empty,
    input  logic            pop,
    output logic [CP_W-1:0] codepoint,
    output logic            run_last
);

    logic [REP_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic [CP_W-1:0]  cp_reg;
    logic             last_reg;

    logic             advance;
    logic [SEQ_W-1:0] total;
    logic             is_last;
    logic [CP_W-1:0]  cp_sel;

    assign total   = SEQ_W'(head_job.rep_count) + SEQ_W'(head_job.has_final);
    assign is_last = ((SEQ_W'(idx_reg) + SEQ_W'(1)) == total);
    assign cp_sel  = (idx_reg < head_job.rep_count) ? REPLACEMENT_CP : head_job.final_cp;

    // The result register loads the head job's next beat when free or popped.
    assign advance   = head_valid && (!out_valid_reg || pop);
    assign head_done = advance && is_last;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cp_reg   <= cp_sel;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
            if (advance)
                idx_reg <= is_last ? '0 : idx_reg + REP_W'(1);
        end
    end

    assign empty     = !out_valid_reg;
    assign codepoint = cp_reg;
    assign run_last  = last_reg;

`ifndef SYNTHESIS
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (SEQ_W'(idx_reg) < total))
        else $error("result index beyond the head job");
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (idx_reg == '0))
        else $error("result index left over with no job");
`endif

endmodule

### rtl/core/utf8_codepoint_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_top: streaming UTF-8 to codepoint decoder
// Input side: push/full with text_byte, one byte per beat.
// Output side: empty/pop with codepoint and run_last, one result per beat.
// Each byte gives zero to four results; run_last marks the last one of a
// byte. Malformed input gives '?' once for each byte swallowed. A zero
// byte ends the string: it flushes any open sequence and gives no result of its own.
// A byte's first result passes through the job queue and then the result
// register before it reaches the ports.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver pops; the back end expands one result per cycle, and a
// four-entry job queue absorbs the bursts of bytes with more results.
// When the receiver stalls the result register holds, the queue fills and
// full rises; no result is lost or repeated.
// Reset clears the sequence tracker, the job queue and the result register.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_top
    import u8cd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] text_byte,
    output logic              empty,
    input  logic              pop,
    output logic [CP_W-1:0]   codepoint,
    output logic              run_last
);

    logic take;
    logic job_push;
    job_t job;
    logic head_valid;
    job_t head_job;
    logic head_done;

    assign take = push && !full;

    u8cd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .text_byte (text_byte),
        .job_push  (job_push),
        .job       (job)
    );

    u8cd_job_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (job_push),
        .wr_job     (job),
        .full       (full),
        .rd_en      (head_done),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u8cd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .head_done  (head_done),
        .empty      (empty),
        .pop        (pop),
        .codepoint  (codepoint),
        .run_last   (run_last)
    );

endmodule

### verif/utf8_codepoint_decoder_top_test.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_top_test: self-checking bench for the UTF-8 decoder
// A clocked driver pushes text bytes from a backlog that the stimulus
// process fills: first hand-picked sequences, then random text made mostly
// of well-formed sequences, mixed with truncated sequences, terminators and
// noise. Every accepted byte runs through a local decoder model that queues
// the codepoints it should produce. A clocked monitor pops results and
// compares each beat with the oldest queued codepoint. Both sides idle at
// random, and the receiver also holds off long enough to fill the block.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_top_test
    import u8cd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 3000;
    localparam int RX_HOLD_LEN  = 150;
    localparam int RANDOM_CHUNK = 132;

    typedef struct packed {
        logic [CP_W-1:0] codepoint;
        logic            run_last;
    } cp_beat_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              push      = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] text_byte = '0;
    logic              empty;
    logic              pop       = 1'b0;
    logic [CP_W-1:0]   codepoint;
    logic              run_last;

    logic [BYTE_W-1:0] text_backlog[$];
    cp_beat_t          expected_cps[$];
    cp_beat_t          head_beat;

    // Open-sequence state of the local decoder model.
    logic [SEQ_W-1:0]  open_len   = SEQ_IDLE;
    logic [2:0]        open_taken = '0;
    logic [CP_W-1:0]   open_bits  = '0;

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_asks = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;
    int fail_count   = 0;

    utf8_codepoint_decoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .text_byte (text_byte),
        .empty     (empty),
        .pop       (pop),
        .codepoint (codepoint),
        .run_last  (run_last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Works out the codepoints that one accepted byte causes and queues them.
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [CP_W-1:0] burst[$];
        int              swallowed;
        bit              fresh;
        cp_beat_t        beat;

        fresh = 1'b1;
        if (open_len != SEQ_IDLE)
        begin
            if ((b & CONT_MASK) == CONT_CODE)
            begin
                fresh      = 1'b0;
                open_bits  = {open_bits[CP_W-7:0], b[5:0]};
                open_taken = open_taken + 3'd1;
                if (open_taken >= open_len)
                begin
                    burst.push_back(open_bits);
                    open_len   = SEQ_IDLE;
                    open_taken = '0;
                    open_bits  = '0;
                end
            end
            else
            begin
                // A broken sequence gives one replacement per byte swallowed.
                swallowed = open_taken;
                if (swallowed < 1)
                    swallowed = 1;
                if (swallowed > 3)
                    swallowed = 3;
                repeat (swallowed) burst.push_back(REPLACEMENT_CP);
                open_len   = SEQ_IDLE;
                open_taken = '0;
                open_bits  = '0;
            end
        end
        if (fresh && b != '0)
        begin
            if (b < 8'h80)
                burst.push_back(CP_W'(b));
            else if ((b & LEAD2_MASK) == LEAD2_CODE)
            begin
                open_bits  = CP_W'(b & ~LEAD2_MASK);
                open_len   = SEQ_TWO;
                open_taken = 3'd1;
            end
            else if ((b & LEAD3_MASK) == LEAD3_CODE)
            begin
                open_bits  = CP_W'(b & ~LEAD3_MASK);
                open_len   = SEQ_THREE;
                open_taken = 3'd1;
            end
            else if ((b & LEAD4_MASK) == LEAD4_CODE)
            begin
                open_bits  = CP_W'(b & ~LEAD4_MASK);
                open_len   = SEQ_FOUR;
                open_taken = 3'd1;
            end
            else
                burst.push_back(REPLACEMENT_CP);
        end
        for (int i = 0; i < burst.size(); i++)
        begin
            beat.codepoint = burst[i];
            beat.run_last  = (i == burst.size() - 1);
            expected_cps.push_back(beat);
        end
    endtask

    function automatic logic [BYTE_W-1:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // Appends about n bytes of random text, mostly well-formed sequences.
    task automatic append_random_text(input int n);
        int                start;
        int                pick;
        int                seq_bytes;
        logic [BYTE_W-1:0] b;

        start = text_backlog.size();
        while (text_backlog.size() - start < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                text_backlog.push_back(BYTE_W'($urandom_range(1, 127)));
            else if (pick < 30)
                text_backlog.push_back('0);
            else if (pick < 45)
            begin
                text_backlog.push_back({3'b110, 5'($urandom)});
                text_backlog.push_back(cont_byte());
            end
            else if (pick < 60)
            begin
                text_backlog.push_back({4'b1110, 4'($urandom)});
                repeat (2) text_backlog.push_back(cont_byte());
            end
            else if (pick < 75)
            begin
                text_backlog.push_back({5'b11110, 3'($urandom)});
                repeat (3) text_backlog.push_back(cont_byte());
            end
            else if (pick < 88)
            begin
                // A sequence cut short by a byte that is not a continuation.
                seq_bytes = $urandom_range(2, 4);
                case (seq_bytes)
                    2: text_backlog.push_back({3'b110, 5'($urandom)});
                    3: text_backlog.push_back({4'b1110, 4'($urandom)});
                    default: text_backlog.push_back({5'b11110, 3'($urandom)});
                endcase
                repeat ($urandom_range(0, seq_bytes - 2)) text_backlog.push_back(cont_byte());
                b = BYTE_W'($urandom_range(0, 255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                text_backlog.push_back(b);
            end
            else
                text_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Waits until every byte is in and every result is out.
    task automatic drain_all();
        while (text_backlog.size() != 0 || push)
            @(posedge clk);
        while (expected_cps.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push      <= 1'b0;
            text_byte <= '0;
        end
        else
        begin
            if (push && !full)
                decode_byte(text_byte);
            if (!(push && full))
            begin
                if (text_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    push      <= 1'b1;
                    text_byte <= text_backlog.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop          <= 1'b0;
            rx_hold_seen <= 0;
            rx_hold_left <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_cps.size() == 0)
                begin
                    $error("unexpected result beat: codepoint=%0h run_last=%0b",
                           codepoint, run_last);
                    fail_count++;
                end
                else
                begin
                    head_beat = expected_cps.pop_front();
                    if (codepoint !== head_beat.codepoint)
                    begin
                        $error("codepoint: expected %0h, got %0h",
                               head_beat.codepoint, codepoint);
                        fail_count++;
                    end
                    if (run_last !== head_beat.run_last)
                    begin
                        $error("run_last: expected %0b, got %0b",
                               head_beat.run_last, run_last);
                        fail_count++;
                    end
                end
            end
            if (rx_hold_seen != rx_hold_asks)
            begin
                rx_hold_seen <= rx_hold_asks;
                rx_hold_left <= RX_HOLD_LEN;
                pop          <= 1'b0;
            end
            else if (rx_hold_left > 0)
            begin
                rx_hold_left <= rx_hold_left - 1;
                pop          <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct <= 16;
        rx_idle_pct <= 76;
        // An ASCII letter, the largest ASCII value and a terminator while idle.
        text_backlog.push_back(8'h41);
        text_backlog.push_back(8'h7F);
        text_backlog.push_back(8'h00);
        // Complete two, three and four byte sequences, the last the largest value.
        text_backlog.push_back(8'hC3);
        text_backlog.push_back(8'hA9);
        text_backlog.push_back(8'hEF);
        text_backlog.push_back(8'hBF);
        text_backlog.push_back(8'hBF);
        text_backlog.push_back(8'hF7);
        text_backlog.push_back(8'hBF);
        text_backlog.push_back(8'hBF);
        text_backlog.push_back(8'hBF);
        // Invalid leads: a stray continuation and the 11111xxx range.
        text_backlog.push_back(8'h80);
        text_backlog.push_back(8'hFF);
        text_backlog.push_back(8'hF8);
        // A lead broken by ASCII, a four byte lead broken after three bytes,
        // a lead flushed by a terminator and a lead broken by another lead.
        text_backlog.push_back(8'hC3);
        text_backlog.push_back(8'h41);
        text_backlog.push_back(8'hF4);
        text_backlog.push_back(8'h80);
        text_backlog.push_back(8'h80);
        text_backlog.push_back(8'h41);
        text_backlog.push_back(8'hE0);
        text_backlog.push_back(8'h00);
        text_backlog.push_back(8'hC0);
        text_backlog.push_back(8'hC0);
        text_backlog.push_back(8'h80);
        drain_all();

        append_random_text(RANDOM_CHUNK);
        drain_all();

        tx_idle_pct <= 76;
        rx_idle_pct <= 16;
        append_random_text(RANDOM_CHUNK);
        drain_all();

        // No idling; the receiver holds off at the start so the block backs up.
        tx_idle_pct  <= 0;
        rx_idle_pct  <= 0;
        rx_hold_asks <= rx_hold_asks + 1;
        append_random_text(RANDOM_CHUNK);
        drain_all();

        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_cps.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
